[src/two_value_key_table_core_assert.svh]
// ----------------------------------------------------------------------------
// Two-value key table assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TWO_VALUE_KEY_TABLE_CORE_ASSERT_SVH
`define TWO_VALUE_KEY_TABLE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TVKT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TVKT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/tvkt_pkg.sv]
// ----------------------------------------------------------------------------
// Two-value key table package
// Beat types, operation and status codes, and the controller to datapath
// command and status groups.
// ----------------------------------------------------------------------------
package tvkt_pkg;

   // Field widths fixed by the interface.
   localparam int COUNT_WIDTH = 5;
   localparam int DATA_WIDTH  = 32;

   // Capacity register value after reset.
   localparam logic [COUNT_WIDTH-1:0] CAP_RESET = 5'd16;

   // Operation codes.
   localparam logic [1:0] OP_ADD        = 2'd0;
   localparam logic [1:0] OP_SEARCH     = 2'd1;
   localparam logic [1:0] OP_REMOVE     = 2'd2;
   localparam logic [1:0] OP_REMOVE_KEY = 2'd3;

   // Result status codes.
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // Request beat.
   typedef struct packed {
      logic [1:0]                   opcode;
      logic signed [DATA_WIDTH-1:0] key;
      logic signed [DATA_WIDTH-1:0] value;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [1:0]                   status;
      logic signed [DATA_WIDTH-1:0] first_value;
      logic                         first_found;
      logic signed [DATA_WIDTH-1:0] second_value;
      logic                         second_found;
      logic [COUNT_WIDTH-1:0]       pair_count;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;          // capture the request beat
      logic       scan_start;    // clear the scan engine
      logic       scan_run;      // step the scan engine one entry
      logic       kv_mode;       // scan for key and value instead of key only
      logic       sel_v1;        // compare against the second found value
      logic       use_first_idx; // remove the first key hit directly
      logic       add_write;     // append the request pair
      logic       move_read;     // read the last entry
      logic       move_write;    // move the last entry into the hit slot
      logic       respond;       // register the result beat
      logic       report_values; // show found values in the result
      logic [1:0] rsp_status;    // status code of the result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] opcode;
      logic       full;
      logic       scan_done;
      logic       kv_found;
      logic [1:0] hits;
   } stat_type;

endpackage

[src/tvkt_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tvkt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/tvkt_datapath.sv]
// ----------------------------------------------------------------------------
// Two-value key table datapath
// Pair store, count and capacity registers, scan engine and result register.
// ----------------------------------------------------------------------------
module tvkt_datapath #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tvkt_pkg::req_type                    req_data,
   input  logic                                 csr_we,
   input  logic [tvkt_pkg::COUNT_WIDTH-1:0]     csr_data,
   input  tvkt_pkg::cmd_type                    cmd,
   output tvkt_pkg::stat_type                   stat,
   output logic                                 rsp_strobe,
   output tvkt_pkg::rsp_type                    rsp_data
);

   localparam int AddrWidth  = $clog2(TABLE_DEPTH);
   localparam int CountWidth = tvkt_pkg::COUNT_WIDTH;
   localparam int DataWidth  = tvkt_pkg::DATA_WIDTH;

   tvkt_pkg::req_type      req_ff, req_in;
   logic [CountWidth-1:0]  cap_ff, cap_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [CountWidth-1:0]  idx_ff, idx_in;
   logic                   rv_ff, rv_in;
   logic [AddrWidth-1:0]   ridx_ff, ridx_in;
   logic                   kvmode_ff, kvmode_in;
   logic [DataWidth-1:0]   cmpv_ff, cmpv_in;
   logic [1:0]             hits_ff, hits_in;
   logic [DataWidth-1:0]   v0_ff, v0_in;
   logic [DataWidth-1:0]   v1_ff, v1_in;
   logic [AddrWidth-1:0]   i0_ff, i0_in;
   logic [AddrWidth-1:0]   midx_ff, midx_in;
   logic                   kvfound_ff, kvfound_in;
   tvkt_pkg::rsp_type      rsp_ff, rsp_in;
   logic                   strobe_ff, strobe_in;

   logic                   ram_we;
   logic [AddrWidth-1:0]   ram_waddr;
   logic [2*DataWidth-1:0] ram_wdata;
   logic [AddrWidth-1:0]   ram_raddr;
   logic [2*DataWidth-1:0] ram_rdata;

   logic [DataWidth-1:0]   rd_key;
   logic [DataWidth-1:0]   rd_val;
   logic [CountWidth-1:0]  last_idx;
   logic                   key_hit;
   logic                   kv_hit;
   logic                   term_hit;
   logic                   issue;
   logic                   full;

   // Pair store: key in the upper half of the word, value in the lower half.
   tvkt_ram #(
      .WIDTH (2*DataWidth),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_key   = ram_rdata[2*DataWidth-1:DataWidth];
   assign rd_val   = ram_rdata[DataWidth-1:0];
   assign last_idx = count_ff - CountWidth'(1);

   // Compare stage of the scan: the entry read in the previous cycle.
   assign key_hit  = rv_ff && (rd_key == req_ff.key);
   assign kv_hit   = key_hit && (rd_val == cmpv_ff);
   assign term_hit = kvmode_ff ? kv_hit : (key_hit && (hits_ff == 2'd1));
   assign issue    = cmd.scan_run && (idx_ff < count_ff);

   // The table is full at the capacity register or at the store depth.
   assign full = (count_ff >= cap_ff) || (int'(count_ff) >= TABLE_DEPTH);

   // Store port selection.
   always_comb begin
      ram_we    = cmd.add_write || cmd.move_write;
      ram_waddr = cmd.move_write ? midx_ff : AddrWidth'(count_ff);
      ram_wdata = cmd.move_write ? ram_rdata : {req_ff.key, req_ff.value};
      ram_raddr = cmd.move_read ? AddrWidth'(last_idx) : AddrWidth'(idx_ff);
   end

   // Next state of the datapath registers.
   always_comb begin
      req_in     = req_ff;
      cap_in     = cap_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      rv_in      = rv_ff;
      ridx_in    = ridx_ff;
      kvmode_in  = kvmode_ff;
      cmpv_in    = cmpv_ff;
      hits_in    = hits_ff;
      v0_in      = v0_ff;
      v1_in      = v1_ff;
      i0_in      = i0_ff;
      midx_in    = midx_ff;
      kvfound_in = kvfound_ff;
      rsp_in     = rsp_ff;
      strobe_in  = cmd.respond;

      if (cmd.load) begin
         req_in = req_data;
      end
      if (csr_we) begin
         cap_in = csr_data;
      end

      // A new scan clears the engine; a key scan also clears the found values.
      if (cmd.scan_start) begin
         idx_in     = '0;
         rv_in      = 1'b0;
         kvfound_in = 1'b0;
         kvmode_in  = cmd.kv_mode;
         cmpv_in    = cmd.sel_v1 ? v1_ff : req_ff.value;
         if (!cmd.kv_mode) begin
            hits_in = 2'd0;
            v0_in   = '0;
            v1_in   = '0;
         end
      end

      // One read is issued per cycle while the scan runs and entries remain; its compare follows in the next cycle.
      if (cmd.scan_run) begin
         rv_in   = issue;
         ridx_in = AddrWidth'(idx_ff);
         idx_in  = idx_ff + CountWidth'(issue);
         if (kvmode_ff) begin
            if (kv_hit && !kvfound_ff) begin
               kvfound_in = 1'b1;
               midx_in    = ridx_ff;
            end
         end else if (key_hit && (hits_ff != 2'd2)) begin
            if (hits_ff == 2'd0) begin
               v0_in = rd_val;
               i0_in = ridx_ff;
            end else begin
               v1_in = rd_val;
            end
            hits_in = hits_ff + 2'd1;
         end
      end

      if (cmd.use_first_idx) begin
         midx_in = i0_ff;
      end

      if (cmd.add_write) begin
         count_in = count_ff + CountWidth'(1);
      end
      if (cmd.move_write) begin
         count_in = last_idx;
      end

      // Result beat.
      if (cmd.respond) begin
         rsp_in.status       = cmd.rsp_status;
         rsp_in.first_found  = cmd.report_values && (hits_ff != 2'd0);
         rsp_in.second_found = cmd.report_values && (hits_ff == 2'd2);
         rsp_in.first_value  = (cmd.report_values && (hits_ff != 2'd0)) ? v0_ff : '0;
         rsp_in.second_value = (cmd.report_values && (hits_ff == 2'd2)) ? v1_ff : '0;
         rsp_in.pair_count   = count_ff;
      end
   end

   // Control registers take reset; payload registers do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= tvkt_pkg::CAP_RESET;
         count_ff   <= '0;
         rv_ff      <= 1'b0;
         strobe_ff  <= 1'b0;
         kvfound_ff <= 1'b0;
         hits_ff    <= 2'd0;
      end else begin
         cap_ff     <= cap_in;
         count_ff   <= count_in;
         rv_ff      <= rv_in;
         strobe_ff  <= strobe_in;
         kvfound_ff <= kvfound_in;
         hits_ff    <= hits_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      idx_ff    <= idx_in;
      ridx_ff   <= ridx_in;
      kvmode_ff <= kvmode_in;
      cmpv_ff   <= cmpv_in;
      v0_ff     <= v0_in;
      v1_ff     <= v1_in;
      i0_ff     <= i0_in;
      midx_ff   <= midx_in;
      rsp_ff    <= rsp_in;
   end

   // Status toward the controller; hits and found show the value after this edge.
   always_comb begin
      stat.opcode    = req_ff.opcode;
      stat.full      = full;
      stat.scan_done = (rv_ff && term_hit) || (!rv_ff && (idx_ff >= count_ff));
      stat.kv_found  = kvfound_in;
      stat.hits      = hits_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[src/tvkt_controller.sv]
// ----------------------------------------------------------------------------
// Two-value key table controller
// State machine that sequences scans, appends, moves and the result beat.
// ----------------------------------------------------------------------------
module tvkt_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  tvkt_pkg::stat_type stat,
   output tvkt_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CHECK   = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_ADD_WR  = 3'd3;
   localparam logic [2:0] S_MOVE_RD = 3'd4;
   localparam logic [2:0] S_MOVE_WR = 3'd5;
   localparam logic [2:0] S_RESP    = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       phase_ff, phase_in;  // second removal of a remove-key request
   logic [1:0] code_ff, code_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      code_in  = code_ff;
      cmd      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               phase_in = 1'b0;
               state_in = S_CHECK;
            end
         end

         // Full check for add, then start the scan that fits the operation.
         S_CHECK: begin
            unique case (stat.opcode) inside
               tvkt_pkg::OP_ADD: begin
                  if (stat.full) begin
                     code_in  = tvkt_pkg::ST_FULL;
                     state_in = S_RESP;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               tvkt_pkg::OP_SEARCH, tvkt_pkg::OP_REMOVE_KEY: begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
               default: begin
                  cmd.scan_start = 1'b1;
                  cmd.kv_mode    = 1'b1;
                  state_in       = S_SCAN;
               end
            endcase
         end

         // Step the scan and decide on its outcome.
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               if (phase_ff) begin
                  if (stat.kv_found) begin
                     state_in = S_MOVE_RD;
                  end else begin
                     code_in  = tvkt_pkg::ST_DONE;
                     state_in = S_RESP;
                  end
               end else begin
                  unique case (stat.opcode) inside
                     tvkt_pkg::OP_ADD: begin
                        if (stat.hits == 2'd2) begin
                           code_in  = tvkt_pkg::ST_MISS;
                           state_in = S_RESP;
                        end else begin
                           state_in = S_ADD_WR;
                        end
                     end
                     tvkt_pkg::OP_SEARCH: begin
                        code_in  = (stat.hits != 2'd0) ? tvkt_pkg::ST_DONE
                                                       : tvkt_pkg::ST_MISS;
                        state_in = S_RESP;
                     end
                     tvkt_pkg::OP_REMOVE: begin
                        if (stat.kv_found) begin
                           state_in = S_MOVE_RD;
                        end else begin
                           code_in  = tvkt_pkg::ST_MISS;
                           state_in = S_RESP;
                        end
                     end
                     default: begin
                        if (stat.hits == 2'd0) begin
                           code_in  = tvkt_pkg::ST_MISS;
                           state_in = S_RESP;
                        end else begin
                           cmd.use_first_idx = 1'b1;
                           state_in          = S_MOVE_RD;
                        end
                     end
                  endcase
               end
            end
         end

         S_ADD_WR: begin
            cmd.add_write = 1'b1;
            code_in       = tvkt_pkg::ST_DONE;
            state_in      = S_RESP;
         end

         S_MOVE_RD: begin
            cmd.move_read = 1'b1;
            state_in      = S_MOVE_WR;
         end

         // Move the last entry; remove-key with two hits rescans for the second.
         S_MOVE_WR: begin
            cmd.move_write = 1'b1;
            if (!phase_ff && (stat.opcode == tvkt_pkg::OP_REMOVE_KEY) &&
                (stat.hits == 2'd2)) begin
               cmd.scan_start = 1'b1;
               cmd.kv_mode    = 1'b1;
               cmd.sel_v1     = 1'b1;
               phase_in       = 1'b1;
               state_in       = S_SCAN;
            end else begin
               code_in  = tvkt_pkg::ST_DONE;
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            cmd.respond       = 1'b1;
            cmd.rsp_status    = code_ff;
            cmd.report_values = (stat.opcode == tvkt_pkg::OP_SEARCH) ||
                                (stat.opcode == tvkt_pkg::OP_REMOVE_KEY);
            state_in          = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 1'b0;
         code_ff  <= tvkt_pkg::ST_DONE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         code_ff  <= code_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

[src/two_value_key_table_core.sv]
// ----------------------------------------------------------------------------
// Two-value key table core
// Unsorted table of key and value pairs with a programmable capacity, at most two values per key.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Beat
//   -------   ------------------   -----------------------------------------
//   req_      start && !busy       opcode, key, value (req_data)
//   rsp_      rsp_strobe           status, values, found flags, pair_count
//   csr_      csr_valid && ready   table_capacity (csr_data)
//
// Busy stays high for the whole of a request. A scan steps through the stored
// pairs, since the store's single read port scans one entry per cycle, and a
// remove-key with two hits scans twice. The result beat shows in the first
// cycle with busy low; no stall.
// Reset (synchronous) empties the table and sets the capacity to 16; the
// store itself is not cleared. The capacity is written only while idle.
//
module two_value_key_table_core #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  tvkt_pkg::req_type                req_data,
   output logic                             rsp_strobe,
   output tvkt_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tvkt_pkg::COUNT_WIDTH-1:0] csr_data
);

   tvkt_pkg::cmd_type  cmd;
   tvkt_pkg::stat_type stat;
   logic               csr_we;

   // The capacity register takes a beat whenever no request is in progress.
   assign csr_ready = !busy;
   assign csr_we    = csr_valid && csr_ready;

   tvkt_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   tvkt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

[src/tvkt_checker.sv]
// ----------------------------------------------------------------------------
// Two-value key table port checker
// Checks on the top-level ports over time, attached by bind.
// ----------------------------------------------------------------------------
`include "two_value_key_table_core_assert.svh"

module tvkt_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input tvkt_pkg::rsp_type rsp_data,
   input logic              csr_ready
);

   logic status_legal;
   logic fields_ok;

   assign status_legal = (rsp_data.status == tvkt_pkg::ST_DONE) ||
                         (rsp_data.status == tvkt_pkg::ST_MISS) ||
                         (rsp_data.status == tvkt_pkg::ST_FULL);

   // A second value is reported only with a first one, and the status is a known code.
   assign fields_ok = status_legal && (rsp_data.first_found || !rsp_data.second_found);

   // An accepted request keeps the block busy in the next cycle.
   `TVKT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "no busy after accept")

   // A result beat is shown only once the request has finished.
   `TVKT_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_strobe, !busy && csr_ready, "result while busy")

   // One request gives one result beat, never two in a row.
   `TVKT_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_strobe, !rsp_strobe, "repeated result beat")

   // Result fields are consistent.
   `TVKT_ASSERT_NOW(a_rsp_fields, clock, reset, rsp_strobe, fields_ok, "bad result fields")

endmodule

bind two_value_key_table_core tvkt_checker u_tvkt_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data),
   .csr_ready  (csr_ready)
);

[tb/key_table_checker.sv]
// ----------------------------------------------------------------------------
// Key table checker
// Watches the request, result and capacity channels of the two-value key
// table, keeps its own copy of the table contents, predicts each result beat
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module key_table_checker #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  tvkt_pkg::req_type                req_data,
   input  logic                             rsp_strobe,
   input  tvkt_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [tvkt_pkg::COUNT_WIDTH-1:0] csr_data,
   output int                               beats_outstanding,
   output int                               mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the table and of the capacity register.
   logic signed [tvkt_pkg::DATA_WIDTH-1:0] shadow_keys [TABLE_DEPTH];
   logic signed [tvkt_pkg::DATA_WIDTH-1:0] shadow_values [TABLE_DEPTH];
   int                                     shadow_count = 0;
   logic [tvkt_pkg::COUNT_WIDTH-1:0]       shadow_capacity = tvkt_pkg::CAP_RESET;

   // Result beats predicted for accepted requests, oldest first.
   tvkt_pkg::rsp_type predicted_results [$];
   int                fail_total = 0;

   // Collect up to two values stored under a key, in table order.
   function automatic int find_values(
      input  logic signed [tvkt_pkg::DATA_WIDTH-1:0] k,
      output logic signed [tvkt_pkg::DATA_WIDTH-1:0] v0,
      output logic signed [tvkt_pkg::DATA_WIDTH-1:0] v1);
      int hits;
      hits = 0;
      v0 = '0;
      v1 = '0;
      for (int i = 0; i < shadow_count && hits < 2; i++) begin
         if (shadow_keys[i] == k) begin
            if (hits == 0) v0 = shadow_values[i];
            else v1 = shadow_values[i];
            hits++;
         end
      end
      return hits;
   endfunction

   // Delete the first pair that matches; the last entry fills the hole.
   function automatic bit drop_pair(input logic signed [tvkt_pkg::DATA_WIDTH-1:0] k,
                                    input logic signed [tvkt_pkg::DATA_WIDTH-1:0] v);
      int last;
      for (int i = 0; i < shadow_count; i++) begin
         if (shadow_keys[i] == k && shadow_values[i] == v) begin
            last = shadow_count - 1;
            shadow_keys[i] = shadow_keys[last];
            shadow_values[i] = shadow_values[last];
            shadow_count--;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Apply one request to the shadow table and build the result beat.
   function automatic tvkt_pkg::rsp_type apply_request(input tvkt_pkg::req_type r);
      tvkt_pkg::rsp_type                      res;
      logic signed [tvkt_pkg::DATA_WIDTH-1:0] v0;
      logic signed [tvkt_pkg::DATA_WIDTH-1:0] v1;
      int                                     hits;
      int                                     room;
      res = '0;
      hits = 0;
      v0 = '0;
      v1 = '0;
      room = shadow_capacity;
      if (room > TABLE_DEPTH) room = TABLE_DEPTH;
      case (r.opcode)
         tvkt_pkg::OP_ADD: begin
            // The full check wins over the two-values check.
            if (shadow_count >= room) begin
               res.status = tvkt_pkg::ST_FULL;
            end else if (find_values(r.key, v0, v1) >= 2) begin
               res.status = tvkt_pkg::ST_MISS;
            end else if (shadow_count < TABLE_DEPTH) begin
               shadow_keys[shadow_count] = r.key;
               shadow_values[shadow_count] = r.value;
               shadow_count++;
               res.status = tvkt_pkg::ST_DONE;
            end else begin
               res.status = tvkt_pkg::ST_FULL;
            end
         end
         tvkt_pkg::OP_SEARCH: begin
            hits = find_values(r.key, v0, v1);
            res.status = (hits > 0) ? tvkt_pkg::ST_DONE : tvkt_pkg::ST_MISS;
         end
         tvkt_pkg::OP_REMOVE: begin
            res.status = drop_pair(r.key, r.value) ? tvkt_pkg::ST_DONE : tvkt_pkg::ST_MISS;
         end
         tvkt_pkg::OP_REMOVE_KEY: begin
            hits = find_values(r.key, v0, v1);
            if (hits >= 1) void'(drop_pair(r.key, v0));
            if (hits >= 2) void'(drop_pair(r.key, v1));
            res.status = (hits > 0) ? tvkt_pkg::ST_DONE : tvkt_pkg::ST_MISS;
         end
      endcase
      // Only search and remove-key set hits, so other beats show zeros.
      res.first_found = (hits >= 1);
      res.first_value = (hits >= 1) ? v0 : '0;
      res.second_found = (hits >= 2);
      res.second_value = (hits >= 2) ? v1 : '0;
      res.pair_count = shadow_count[tvkt_pkg::COUNT_WIDTH-1:0];
      return res;
   endfunction

   task automatic flag_field(input string field,
                             input logic [tvkt_pkg::DATA_WIDTH-1:0] want,
                             input logic [tvkt_pkg::DATA_WIDTH-1:0] got);
      $error("result field %s: expected %0h, got %0h", field, want, got);
      fail_total++;
   endtask

   // Sample every channel at the clock edge; requests are predicted before
   // results are compared, so a result beat always meets its own prediction.
   always @(posedge clock) begin : watch
      tvkt_pkg::rsp_type want;
      if (reset) begin
         shadow_count = 0;
         shadow_capacity = tvkt_pkg::CAP_RESET;
         predicted_results.delete();
      end else begin
         if (csr_valid && csr_ready) shadow_capacity = csr_data;
         if (start && !busy) predicted_results.push_back(apply_request(req_data));
         if (rsp_strobe) begin
            if (predicted_results.size() == 0) begin
               $error("result beat with no request waiting for it");
               fail_total++;
            end else begin
               want = predicted_results.pop_front();
               if (rsp_data.status !== want.status)
                  flag_field("status", want.status, rsp_data.status);
               if (rsp_data.first_value !== want.first_value)
                  flag_field("first_value", want.first_value, rsp_data.first_value);
               if (rsp_data.first_found !== want.first_found)
                  flag_field("first_found", want.first_found, rsp_data.first_found);
               if (rsp_data.second_value !== want.second_value)
                  flag_field("second_value", want.second_value, rsp_data.second_value);
               if (rsp_data.second_found !== want.second_found)
                  flag_field("second_found", want.second_found, rsp_data.second_found);
               if (rsp_data.pair_count !== want.pair_count)
                  flag_field("pair_count", want.pair_count, rsp_data.pair_count);
            end
         end
      end
      beats_outstanding <= predicted_results.size();
      mismatch_count <= fail_total;
   end

endmodule

[tb/two_value_key_table_core_tb.sv]
// ----------------------------------------------------------------------------
// Two-value key table testbench
// Drives a directed run over the field extremes and every operation, then
// random phases under several capacity settings with idle gaps. A checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module two_value_key_table_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH  = 16;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 20;
   localparam int PHASE_ITEMS  = 190;
   localparam int PHASES       = 10;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   tvkt_pkg::req_type                req_data = '0;
   logic                             rsp_strobe;
   tvkt_pkg::rsp_type                rsp_data;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [tvkt_pkg::COUNT_WIDTH-1:0] csr_data = '0;

   int beats_outstanding;
   int mismatch_count;
   int quiet_cycles = 0;

   // Per-phase pools that keep keys and values colliding.
   logic signed [tvkt_pkg::DATA_WIDTH-1:0] key_pool [12];
   logic signed [tvkt_pkg::DATA_WIDTH-1:0] value_pool [3];
   int                                     key_pool_size;
   int                                     add_weight;

   logic [tvkt_pkg::COUNT_WIDTH-1:0] phase_capacity [PHASES] =
      '{5'd0, 5'd1, 5'd2, 5'd16, 5'd5, 5'd31, 5'd3, 5'd12, 5'd17, 5'd8};

   two_value_key_table_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   key_table_checker #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_data         (rsp_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .beats_outstanding(beats_outstanding),
      .mismatch_count   (mismatch_count)
   );

   always #5ns clock = ~clock;

   // Any accepted beat on any channel restarts the stall count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic tvkt_pkg::req_type make_request(
      input logic [1:0]                    op,
      input logic [tvkt_pkg::DATA_WIDTH-1:0] k,
      input logic [tvkt_pkg::DATA_WIDTH-1:0] v);
      tvkt_pkg::req_type r;
      r.opcode = op;
      r.key = k;
      r.value = v;
      return r;
   endfunction

   // Hold a request beat until the block takes it, then maybe go idle.
   task automatic issue(input tvkt_pkg::req_type r, input bit no_idle);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (!no_idle && $urandom_range(99) < 9) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 45)) @(posedge clock);
      end
   endtask

   // Write the capacity once the block has drained and gone idle.
   task automatic write_capacity(input logic [tvkt_pkg::COUNT_WIDTH-1:0] cap);
      start <= 1'b0;
      @(posedge clock);
      while (beats_outstanding != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic tvkt_pkg::req_type random_request();
      tvkt_pkg::req_type r;
      int                pick;
      int                rest;
      pick = $urandom_range(99);
      rest = (100 - add_weight) / 3;
      if (pick < add_weight) r.opcode = tvkt_pkg::OP_ADD;
      else if (pick < add_weight + rest) r.opcode = tvkt_pkg::OP_SEARCH;
      else if (pick < add_weight + 2 * rest) r.opcode = tvkt_pkg::OP_REMOVE;
      else r.opcode = tvkt_pkg::OP_REMOVE_KEY;
      // Mostly pooled keys and values, with some fully random noise.
      r.key = ($urandom_range(99) < 88) ? key_pool[$urandom_range(key_pool_size - 1)]
                                        : $urandom();
      r.value = ($urandom_range(99) < 88) ? value_pool[$urandom_range(2)] : $urandom();
      return r;
   endfunction

   task automatic run_phase(input int items, input bit no_idle);
      for (int i = 0; i < 12; i++) key_pool[i] = $urandom();
      for (int i = 0; i < 3; i++) value_pool[i] = $urandom();
      if ($urandom_range(99) < 30) begin
         key_pool[0] = 32'h8000_0000;
         key_pool[1] = 32'h7fff_ffff;
         value_pool[0] = 32'hffff_ffff;
         value_pool[1] = 32'h0000_0000;
      end
      key_pool_size = $urandom_range(2, 12);
      for (int i = 0; i < items; i++) issue(random_request(), no_idle);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed run: capacity above the store depth acts as the depth.
      write_capacity(5'd31);
      issue(make_request(tvkt_pkg::OP_SEARCH, 32'h8000_0000, 32'h0000_007b), 1'b0);
      issue(make_request(tvkt_pkg::OP_REMOVE, 32'h8000_0000, 32'h0000_0000), 1'b0);
      issue(make_request(tvkt_pkg::OP_REMOVE_KEY, 32'h8000_0000, 32'h0000_0000), 1'b0);
      issue(make_request(tvkt_pkg::OP_ADD, 32'h8000_0000, 32'h7fff_ffff), 1'b0);
      issue(make_request(tvkt_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000), 1'b0);
      // A third value for a key is rejected.
      issue(make_request(tvkt_pkg::OP_ADD, 32'h8000_0000, 32'h0000_0000), 1'b0);
      issue(make_request(tvkt_pkg::OP_SEARCH, 32'h8000_0000, 32'hffff_ffff), 1'b0);
      issue(make_request(tvkt_pkg::OP_ADD, 32'h7fff_ffff, 32'hffff_ffff), 1'b0);
      issue(make_request(tvkt_pkg::OP_ADD, 32'h7fff_ffff, 32'hffff_ffff), 1'b0);
      issue(make_request(tvkt_pkg::OP_SEARCH, 32'h7fff_ffff, 32'h0000_0000), 1'b0);
      issue(make_request(tvkt_pkg::OP_ADD, 32'h0000_0000, 32'h0000_0000), 1'b0);
      issue(make_request(tvkt_pkg::OP_ADD, 32'hffff_ffff, 32'hffff_ffff), 1'b0);
      // Key matches but the value does not.
      issue(make_request(tvkt_pkg::OP_REMOVE, 32'hffff_ffff, 32'h0000_0000), 1'b0);
      issue(make_request(tvkt_pkg::OP_REMOVE, 32'h8000_0000, 32'h7fff_ffff), 1'b0);
      issue(make_request(tvkt_pkg::OP_SEARCH, 32'h8000_0000, 32'h0000_0000), 1'b0);
      // Both pairs of this key carry the same value.
      issue(make_request(tvkt_pkg::OP_REMOVE_KEY, 32'h7fff_ffff, 32'h1234_5678), 1'b0);
      issue(make_request(tvkt_pkg::OP_SEARCH, 32'h7fff_ffff, 32'h0000_0000), 1'b0);
      issue(make_request(tvkt_pkg::OP_REMOVE_KEY, 32'h8000_0000, 32'h0000_0000), 1'b0);
      issue(make_request(tvkt_pkg::OP_ADD, 32'h8000_0000, 32'h5555_5555), 1'b0);
      issue(make_request(tvkt_pkg::OP_ADD, 32'h8000_0000, 32'haaaa_aaaa), 1'b0);
      issue(make_request(tvkt_pkg::OP_REMOVE_KEY, 32'h8000_0000, 32'hffff_ffff), 1'b0);
      issue(make_request(tvkt_pkg::OP_SEARCH, 32'h0000_0000, 32'hffff_ffff), 1'b0);

      // Random phases; the first ones run with capacity below the count.
      for (int p = 0; p < PHASES; p++) begin
         write_capacity(phase_capacity[p]);
         add_weight = (phase_capacity[p] >= 12) ? 55 : 40;
         run_phase(PHASE_ITEMS, p == 3);
      end
      start <= 1'b0;

      // Drain, then allow time for any stray beat to show up.
      @(posedge clock);
      while (beats_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/tvkt_pkg.sv
src/tvkt_ram.sv
src/tvkt_datapath.sv
src/tvkt_controller.sv
src/two_value_key_table_core.sv
src/tvkt_checker.sv
tb/key_table_checker.sv
tb/two_value_key_table_core_tb.sv
